>>> rtl/tfpm_pkg.sv
// Shared types, constants and frame pack and merge functions for the timed frame playback merge block.
package tfpm_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 3;
    localparam int FRAME_W         = 64;
    localparam int TIME_W          = 32;

    localparam logic [7:0] STICK_NEUTRAL = 8'd128;
    localparam logic [7:0] HAT_NEUTRAL   = 8'd8;

    localparam logic [MODE_W-1:0] MODE_STORED_PRI = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LIVE_PRI   = 2'd1;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME = 3'd1;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic OP_APPEND = 1'b0;

    localparam logic [0:0] REG_MERGE_MODE = 1'b0;

    typedef logic [FRAME_W-1:0] frame_t;

    typedef struct packed {
        logic        op;
        logic [31:0] time_stamp;
        logic [7:0]  head_byte;
        logic [15:0] button_bits;
        logic [31:0] stick_bytes;
        logic [7:0]  hat_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0]          out_head_byte;
        logic [15:0]         out_button_bits;
        logic [31:0]         out_stick_bytes;
        logic [7:0]          out_hat_byte;
        logic [STATUS_W-1:0] status;
    } rsp_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_STEP,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic append;
        logic search;
        logic update;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_append;
        logic more;
        logic out_free;
    } dp_status_t;

    function automatic frame_t pack_frame(input req_item_t item);
        pack_frame = {item.hat_byte, item.stick_bytes, item.button_bits, item.head_byte};
    endfunction

    function automatic frame_t merge_frames(input frame_t pri, input frame_t oth);
        frame_t r;
        r = '0;
        r[7:0]  = pri[7:0];
        r[23:8] = pri[23:8] | oth[23:8];
        for (int k = 3; k < 7; k++)
        begin
            if (pri[8*k +: 8] == STICK_NEUTRAL)
            begin
                r[8*k +: 8] = oth[8*k +: 8];
            end
            else
            begin
                r[8*k +: 8] = pri[8*k +: 8];
            end
        end
        if (pri[63:56] == HAT_NEUTRAL)
        begin
            r[63:56] = oth[63:56];
        end
        else
        begin
            r[63:56] = pri[63:56];
        end
        merge_frames = r;
    endfunction

endpackage

>>> rtl/tfpm_ctrl.sv
// Controller state machine sequencing append, binary search and result delivery.
module tfpm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  tfpm_pkg::dp_status_t  dp_status,
    output tfpm_pkg::dp_cmd_t     dp_cmd
);
    import tfpm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (dp_status.is_append || !dp_status.more)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (!dp_status.more)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (dp_status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dp_cmd    = '0;
        req_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall      = 1'b0;
                dp_cmd.capture = req_valid;
            end
            S_PROBE:
            begin
                dp_cmd.append = dp_status.is_append;
                dp_cmd.search = !dp_status.is_append;
            end
            S_STEP:
            begin
                dp_cmd.search = 1'b1;
                dp_cmd.update = 1'b1;
            end
            S_DONE:
            begin
                dp_cmd.load_out = dp_status.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/tfpm_dpath.sv
// Datapath: entry tables, fill count, search bounds, merge and result register.
module tfpm_dpath #(
    parameter int TABLE_DEPTH = tfpm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tfpm_pkg::req_item_t              req_data,
    input  logic [tfpm_pkg::MODE_W-1:0]      merge_mode,
    input  tfpm_pkg::dp_cmd_t                dp_cmd,
    output tfpm_pkg::dp_status_t             dp_status,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output tfpm_pkg::rsp_item_t              rsp_data
);
    import tfpm_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [TIME_W-1:0] time_mem [TABLE_DEPTH];
    frame_t            frame_mem [TABLE_DEPTH];

    logic [CW-1:0]       count_reg;
    logic [TIME_W-1:0]   last_time_reg;
    frame_t              last_frame_reg;
    logic                op_reg;
    logic [TIME_W-1:0]   time_reg;
    frame_t              live_reg;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       hi_reg;
    logic [CW-1:0]       mid_reg;
    logic [TIME_W-1:0]   rd_time_reg;
    frame_t              rd_frame_reg;
    logic [STATUS_W-1:0] app_status_reg;
    logic                rsp_valid_reg;
    rsp_item_t           rsp_data_reg;

    logic [CW-1:0]       lo_cur;
    logic [CW-1:0]       hi_cur;
    logic [CW-1:0]       mid_cur;
    logic [CW-1:0]       lo_less1;
    logic                more;
    logic                dup;
    logic                full;
    logic [TIME_W-1:0]   wr_time;
    logic [STATUS_W-1:0] app_status;
    frame_t              res_frame;
    logic [STATUS_W-1:0] res_status;
    rsp_item_t           rsp_data_next;
    logic                out_free;

    assign dup  = (count_reg != '0) && (last_frame_reg == live_reg);
    assign full = (count_reg == DEPTH_C);
    assign wr_time = ((count_reg != '0) && (time_reg < last_time_reg)) ? last_time_reg
                                                                       : time_reg;

    always_comb
    begin
        if (dup)
        begin
            app_status = ST_DUPLICATE;
        end
        else if (full)
        begin
            app_status = ST_FULL;
        end
        else
        begin
            app_status = ST_APPENDED;
        end
    end

    always_comb
    begin
        lo_cur = lo_reg;
        hi_cur = hi_reg;
        if (dp_cmd.update)
        begin
            if (rd_time_reg <= time_reg)
            begin
                lo_cur = mid_reg + CW'(1);
            end
            else
            begin
                hi_cur = mid_reg;
            end
        end
    end

    assign more     = lo_cur < hi_cur;
    assign mid_cur  = lo_cur + ((hi_cur - lo_cur) >> 1);
    assign lo_less1 = lo_cur - CW'(1);

    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign dp_status.is_append = (op_reg == OP_APPEND);
    assign dp_status.more      = more;
    assign dp_status.out_free  = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dp_cmd.append && !dup && !full)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.append && !dup && !full)
        begin
            time_mem[count_reg[AW-1:0]]  <= wr_time;
            frame_mem[count_reg[AW-1:0]] <= live_reg;
            last_time_reg                <= wr_time;
            last_frame_reg               <= live_reg;
        end
        if (dp_cmd.append)
        begin
            app_status_reg <= app_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.search && more)
        begin
            rd_time_reg <= time_mem[mid_cur[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.search && !more && (lo_cur != '0))
        begin
            rd_frame_reg <= frame_mem[lo_less1[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg   <= req_data.op;
            time_reg <= req_data.time_stamp;
            live_reg <= pack_frame(req_data);
            lo_reg   <= '0;
            hi_reg   <= count_reg;
        end
        else if (dp_cmd.search)
        begin
            lo_reg  <= lo_cur;
            hi_reg  <= hi_cur;
            mid_reg <= mid_cur;
        end
    end

    always_comb
    begin
        res_status = ST_FOUND;
        if (lo_reg == '0)
        begin
            res_frame  = live_reg;
            res_status = ST_NO_FRAME;
        end
        else if (merge_mode == MODE_STORED_PRI)
        begin
            res_frame = merge_frames(rd_frame_reg, live_reg);
        end
        else if (merge_mode == MODE_LIVE_PRI)
        begin
            res_frame = merge_frames(live_reg, rd_frame_reg);
        end
        else
        begin
            res_frame = rd_frame_reg;
        end
        if (op_reg == OP_APPEND)
        begin
            res_frame  = '0;
            res_status = app_status_reg;
        end
        rsp_data_next.out_head_byte   = res_frame[7:0];
        rsp_data_next.out_button_bits = res_frame[23:8];
        rsp_data_next.out_stick_bytes = res_frame[55:24];
        rsp_data_next.out_hat_byte    = res_frame[63:56];
        rsp_data_next.status          = res_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (dp_cmd.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

>>> rtl/timed_frame_playback_merge.sv
// Top level: frame table with timed lookup and merge, APB mode register.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_data (op, time, frame)
//   rsp       out        rsp_valid/rsp_stall  rsp_data (frame, status)
//   apb       in         psel/penable/pready  merge_mode at byte 0
//
// One item at a time. An append is captured, written in the probe state and loaded
// into the result register in the done state. A query runs a binary search of at most
// clog2(TABLE_DEPTH)+1 probes, one at a time through the single time-table read port.
// Reset empties the table at once; entries are read only below the fill count.
// A stalled result holds in the output register; the next item is still taken.
module timed_frame_playback_merge #(
    parameter int TABLE_DEPTH = tfpm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  tfpm_pkg::req_item_t  req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output tfpm_pkg::rsp_item_t  rsp_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tfpm_pkg::*;

    localparam logic [1:0] MODE_ADDR = 2'(4 * REG_MERGE_MODE);

    logic [MODE_W-1:0] mode_reg;
    dp_cmd_t           dp_cmd;
    dp_status_t        dp_status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STORED_PRI;
        end
        else if (psel && penable && pwrite && pready && (paddr == MODE_ADDR))
        begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    assign prdata = {{(32 - MODE_W){1'b0}}, mode_reg};

    tfpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    tfpm_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_data   (req_data),
        .merge_mode (mode_reg),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

endmodule
